[rtl/bellman_ford_shortest_path_defines.svh]
// ----------------------------------------------------------------------------
// Bellman-Ford shortest path: assertion macros
// Shared concurrent assertion helpers; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATH_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BFSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsp_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;

  // Fixed field widths
  localparam int VTX_FW      = 6;
  localparam int WT_W        = 16;
  localparam int DIST_W      = 32;
  localparam int EDGE_W      = 2 * VTX_FW + WT_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = VTX_FW + DIST_W + VTX_FW + 2;
  localparam int OUT_TDATA_W = 48;

  // Configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 7;
  localparam logic [CFG_AW-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SOURCE       = 1'b1;
  localparam logic [CFG_DW-1:0] VERTEX_COUNT_RST = 7'd1;

  // Distance of a vertex not yet reached
  localparam logic [DIST_W-1:0] INF_DIST = 32'd99999999;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_edge;  // store accepted edge if room
    logic run_start;  // clear edge/vertex index, pass counter, cycle flag
    logic init_wr;    // write initial distance/pred for current vertex
    logic idx_inc;    // next vertex
    logic edge_rd;    // read edge at current edge index
    logic dist_rd;    // read dist of tail and head
    logic relax;      // compare and update (or flag in check pass)
    logic adv;        // advance to next edge / next pass
    logic out_start;  // drop stored edges, rewind vertex index
    logic out_rd;     // read dist/pred of current vertex
    logic out_load;   // load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_vtx;    // vertex index is the final one in use
    logic edge_empty;  // no edges stored
    logic edge_last;   // edge index is the final stored edge
    logic skip;        // current edge names a vertex out of range
    logic chk;         // current pass is the negative-cycle check
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

[rtl/bfsp_ram.sv]
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re_a,
  input  wire logic [AW-1:0] raddr_a,
  output logic      [W-1:0]  rdata_a,
  input  wire logic          re_b,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [W-1:0]  rdata_b
);

  logic [W-1:0] mem [D];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/bfsp_ctrl.sv]
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Controller: edge load, table init, relaxation passes, result readout.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_ctrl
  import bfsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_INIT   = 8'b0000_0010,
    ST_PASS   = 8'b0000_0100,
    ST_E_RD   = 8'b0000_1000,
    ST_D_RD   = 8'b0001_0000,
    ST_UPD    = 8'b0010_0000,
    ST_OUT_RD = 8'b0100_0000,
    ST_OUT_WR = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_edge = 1'b1;
          if (in_tlast) begin
            cmd.run_start = 1'b1;
            state_nxt     = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.last_vtx) begin
          state_nxt = ST_PASS;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_PASS: begin
        if (sts.edge_empty) begin
          cmd.out_start = 1'b1;
          state_nxt     = ST_OUT_RD;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_E_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = ST_D_RD;
      end
      ST_D_RD: begin
        if (sts.skip) begin
          cmd.adv = 1'b1;
          if (sts.edge_last && sts.chk) begin
            cmd.out_start = 1'b1;
            state_nxt     = ST_OUT_RD;
          end else begin
            state_nxt = ST_E_RD;
          end
        end else begin
          cmd.dist_rd = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.relax = 1'b1;
        cmd.adv   = 1'b1;
        if (sts.edge_last && sts.chk) begin
          cmd.out_start = 1'b1;
          state_nxt     = ST_OUT_RD;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_vtx) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bfsp_dpath.sv]
// ----------------------------------------------------------------------------
// bfsp_dpath
// Datapath: config registers, edge store, dist/pred tables, counters, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_dpath
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_DW-1:0]      cfg_wr_data,
  input  wire logic [EDGE_W-1:0]      edge_in,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic                        out_valid,
  output logic [OUT_FIELD_W-1:0]      out_fields,
  output logic                        out_last,
  input  wire logic                   out_tready
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = VW + 1;
  localparam int PW  = VW + 1;
  localparam int CW  = VTX_FW + 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  // Config registers
  logic [CFG_DW-1:0] vc_r;
  logic [VTX_FW-1:0] src_r;

  // Run control
  logic [EW-1:0] total_r;
  logic [EW-1:0] k_r;
  logic [NW-1:0] pass_r;
  logic [VW-1:0] idx_r;
  logic          neg_r;

  // Result register
  logic                   out_valid_r;
  logic [OUT_FIELD_W-1:0] out_data_r;
  logic                   out_last_r;

  logic [CFG_DW-1:0] n_sat;
  logic [NW-1:0]     n;
  logic              full;
  logic              src_ok;
  logic [EDGE_W-1:0] edge_q;
  logic [VTX_FW-1:0] eu, ev;
  logic [WT_W-1:0]   ew;
  logic [DIST_W-1:0] du, dv, sum;
  logic              relaxable;
  logic [PW-1:0]     pred_q;
  logic [DIST_W-1:0] init_val;
  logic              dist_we;
  logic [VW-1:0]     dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [PW-1:0]     pred_wdata;
  logic [VW-1:0]     dist_raddr_a;

  // Config write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= VERTEX_COUNT_RST;
      src_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_VERTEX_COUNT: vc_r  <= cfg_wr_data;
        REG_SOURCE:       src_r <= cfg_wr_data[VTX_FW-1:0];
        default:          ;
      endcase
    end
  end

  // Vertex count in use, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vc_r == '0) begin
      n_sat = CFG_DW'(1);
    end else if (vc_r > CFG_DW'(MAX_VERTICES)) begin
      n_sat = CFG_DW'(MAX_VERTICES);
    end else begin
      n_sat = vc_r;
    end
  end
  assign n      = n_sat[NW-1:0];
  assign src_ok = {1'b0, src_r} < CW'(n);
  assign full   = (total_r >= EW'(MAX_EDGES));

  // Counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      k_r     <= '0;
      pass_r  <= NW'(1);
      idx_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      if (cmd.out_start) begin
        total_r <= '0;
      end else if (cmd.load_edge && !full) begin
        total_r <= total_r + EW'(1);
      end

      if (cmd.run_start) begin
        k_r    <= '0;
        pass_r <= NW'(1);
      end else if (cmd.adv) begin
        if (sts.edge_last) begin
          k_r    <= '0;
          pass_r <= pass_r + NW'(1);
        end else begin
          k_r <= k_r + EW'(1);
        end
      end

      if (cmd.run_start || cmd.out_start) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + VW'(1);
      end

      if (cmd.run_start) begin
        neg_r <= 1'b0;
      end else if (cmd.relax && sts.chk && relaxable) begin
        neg_r <= 1'b1;
      end
    end
  end

  // Edge store
  bfsp_ram #(.W(EDGE_W), .D(MAX_EDGES), .AW(EAW)) u_edge_ram (
    .clk     (clk),
    .we      (cmd.load_edge && !full),
    .waddr   (total_r[EAW-1:0]),
    .wdata   (edge_in),
    .re_a    (cmd.edge_rd),
    .raddr_a (k_r[EAW-1:0]),
    .rdata_a (edge_q),
    .re_b    (1'b0),
    .raddr_b ('0),
    .rdata_b ()
  );

  assign eu = edge_q[VTX_FW-1:0];
  assign ev = edge_q[2*VTX_FW-1:VTX_FW];
  assign ew = edge_q[EDGE_W-1:2*VTX_FW];

  // Relaxation compare: plain wrapping add and signed compare
  assign sum       = du + {{(DIST_W-WT_W){ew[WT_W-1]}}, ew};
  assign relaxable = $signed(dv) > $signed(sum);

  // Table write/read selection
  assign init_val     = (src_ok && (VTX_FW'(idx_r) == src_r)) ? '0 : INF_DIST;
  assign dist_we      = cmd.init_wr || (cmd.relax && !sts.chk && relaxable);
  assign dist_waddr   = cmd.init_wr ? idx_r : ev[VW-1:0];
  assign dist_wdata   = cmd.init_wr ? init_val : sum;
  assign pred_wdata   = cmd.init_wr ? '0 : {1'b1, eu[VW-1:0]};
  assign dist_raddr_a = cmd.out_rd ? idx_r : eu[VW-1:0];

  bfsp_ram #(.W(DIST_W), .D(MAX_VERTICES), .AW(VW)) u_dist_ram (
    .clk     (clk),
    .we      (dist_we),
    .waddr   (dist_waddr),
    .wdata   (dist_wdata),
    .re_a    (cmd.dist_rd || cmd.out_rd),
    .raddr_a (dist_raddr_a),
    .rdata_a (du),
    .re_b    (cmd.dist_rd),
    .raddr_b (ev[VW-1:0]),
    .rdata_b (dv)
  );

  bfsp_ram #(.W(PW), .D(MAX_VERTICES), .AW(VW)) u_pred_ram (
    .clk     (clk),
    .we      (dist_we),
    .waddr   (dist_waddr),
    .wdata   (pred_wdata),
    .re_a    (cmd.out_rd),
    .raddr_a (idx_r),
    .rdata_a (pred_q),
    .re_b    (1'b0),
    .raddr_b ('0),
    .rdata_b ()
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {neg_r,
                     pred_q[VW],
                     pred_q[VW] ? VTX_FW'(pred_q[VW-1:0]) : VTX_FW'(0),
                     du,
                     VTX_FW'(idx_r)};
      out_last_r <= sts.last_vtx;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_fields = out_data_r;
  assign out_last   = out_last_r;

  // Status
  assign sts.last_vtx   = (NW'(idx_r) == (n - NW'(1)));
  assign sts.edge_empty = (total_r == '0);
  assign sts.edge_last  = ((k_r + EW'(1)) == total_r);
  assign sts.skip       = ({1'b0, eu} >= CW'(n)) || ({1'b0, ev} >= CW'(n));
  assign sts.chk        = (pass_r == n);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

`default_nettype wire

[rtl/bellman_ford_shortest_path.sv]
// Edge load: a new edge each cycle while no run is active.
// Run after the edge marked last: table init per vertex, then n passes
// (n-1 rounds plus the cycle check) of edge read, dist read and update per
// edge (only the edge read if skipped), then a read and a load per result.
// Reset (rst_n low, synchronous) clears the edge count, controller and result
// valid; vertex_count returns to 1, source_vertex to 0.
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path
// Single-source shortest paths with negative-cycle check over streamed edges.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bellman_ford_shortest_path_defines.svh"

module bellman_ford_shortest_path
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_AW-1:0]       cfg_addr,
  input  wire logic [CFG_DW-1:0]       cfg_wr_data,
  // edge requests
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // edge_from, edge_to, edge_weight, pad
  input  wire logic                    in_tlast,   // last_edge
  // results
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // vertex_index, distance, pred_vertex,
                                                   // has_pred, negative_cycle, pad
  output logic                         out_tlast   // last_result
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic [OUT_FIELD_W-1:0] out_fields;

  bfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfsp_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .edge_in     (in_tdata[EDGE_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_fields  (out_fields),
    .out_last    (out_tlast),
    .out_tready  (out_tready)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_fields};

  // Checks
  `BFSP_ASSERT_SAME(a_load_slot, cmd.out_load, !out_tvalid || out_tready,
                    "result loaded over a pending result")
  `BFSP_ASSERT_NEXT(a_run_starts, in_tvalid && in_tready && in_tlast, !in_tready,
                    "last edge did not start a run")
  `BFSP_ASSERT_NEXT(a_run_ends, cmd.out_load && sts.last_vtx, in_tready,
                    "block not ready after final result")

endmodule

`default_nettype wire
